// ===== rtl/mspc_pkg.sv =====
package mspc_pkg;

    localparam int MOTORS = 2;
    localparam int IDX_W  = 1;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_DRIVE = 2'd1;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INT_GAIN_DT = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [2:0] REG_FILTER_COEF = 3'd3;
    localparam logic [2:0] REG_SAMPLE_PER  = 3'd4;
    localparam logic [2:0] REG_CMD_LOW     = 3'd5;
    localparam logic [2:0] REG_CMD_HIGH    = 3'd6;
    localparam logic [2:0] REG_ENC_INVERT  = 3'd7;

    typedef struct packed {
        logic signed [31:0] integ;
        logic signed [31:0] filt;
        logic signed [23:0] target;
        logic [1:0]         mode;
        logic signed [23:0] speed;
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

// ===== rtl/motor_speed_pid_controller.sv =====
// A stop or brake item passes S_IDLE and S_LOAD; a drive item goes on through S_MP,
// S_MD, S_MI, S_MN, S_FO, S_MT and S_FIN. A new item is taken only in S_IDLE; the drive path
// runs five products through one shared 33x25 multiplier, issued in S_MP to S_MN and S_MT.
// A result that cannot leave holds the block in its last state until it does.
// Reset clears all registers to their defaults and marks the per-motor state
// memory empty, so every motor starts in stop with a zero PID state.
module motor_speed_pid_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [0:0]          motor_in,
    input  logic [1:0]          requested_mode,
    input  logic signed [23:0]  target_speed,
    input  logic signed [23:0]  measured_speed,
    input  logic                measured_valid,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [0:0]          motor_out,
    output logic [1:0]          action,
    output logic signed [15:0]  drive_command,
    output logic signed [23:0]  corrected_speed
);
    import mspc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MP, S_MD, S_MI, S_MN, S_FO, S_MT, S_FIN
    } fsm_t;

    logic [23:0]        kp_reg, ki_reg, kd_reg, nf_reg, tp_reg;
    logic signed [15:0] lo_reg, hi_reg;
    logic [1:0]         inv_reg;

    fsm_t               state_reg;
    logic [0:0]         motor_reg;
    logic [1:0]         mode_in_reg;
    logic signed [23:0] target_reg;
    logic signed [23:0] meas_reg;
    logic               mvalid_reg;
    logic signed [24:0] e_reg;
    logic signed [31:0] integ_reg, filt_reg, p_reg, x_reg, fo_reg;
    logic signed [23:0] speed_reg;
    logic signed [44:0] s_reg;
    logic signed [33:0] u_reg;

    logic               out_valid_reg;
    logic [0:0]         motor_out_reg;
    logic [1:0]         action_reg;
    logic signed [15:0] cmd_reg;
    logic signed [23:0] cspeed_reg;

    state_t             rd_data, wr_data;
    logic               wr_en;
    logic               accept;
    logic               out_free;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] prod;

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= '0;
            ki_reg  <= '0;
            kd_reg  <= '0;
            nf_reg  <= '0;
            tp_reg  <= '0;
            lo_reg  <= -16'sd32768;
            hi_reg  <= 16'sd32767;
            inv_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_PROP_GAIN:   kp_reg  <= pwdata[23:0];
                REG_INT_GAIN_DT: ki_reg  <= pwdata[23:0];
                REG_DERIV_GAIN:  kd_reg  <= pwdata[23:0];
                REG_FILTER_COEF: nf_reg  <= pwdata[23:0];
                REG_SAMPLE_PER:  tp_reg  <= pwdata[23:0];
                REG_CMD_LOW:     lo_reg  <= pwdata[15:0];
                REG_CMD_HIGH:    hi_reg  <= pwdata[15:0];
                REG_ENC_INVERT:  inv_reg <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_PROP_GAIN:   prdata = {8'd0, kp_reg};
            REG_INT_GAIN_DT: prdata = {8'd0, ki_reg};
            REG_DERIV_GAIN:  prdata = {8'd0, kd_reg};
            REG_FILTER_COEF: prdata = {8'd0, nf_reg};
            REG_SAMPLE_PER:  prdata = {8'd0, tp_reg};
            REG_CMD_LOW:     prdata = {{16{lo_reg[15]}}, lo_reg};
            REG_CMD_HIGH:    prdata = {{16{hi_reg[15]}}, hi_reg};
            REG_ENC_INVERT:  prdata = {30'd0, inv_reg};
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign motor_out = motor_out_reg;
    assign action    = action_reg;
    assign drive_command   = cmd_reg;
    assign corrected_speed = cspeed_reg;

    mspc_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (motor_in),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (motor_reg),
        .wr_data (wr_data)
    );

    mspc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // item decode against the stored state
    logic               inv_bit;
    logic signed [23:0] corr, speed_new;
    logic [1:0]         mode_eff, act_ld;
    logic               is_drive, restart;
    logic signed [24:0] e_new;

    always_comb
    begin
        inv_bit = inv_reg[motor_reg];
        if (!inv_bit)
            corr = meas_reg;
        else if (meas_reg == -24'sd8388608)
            corr = 24'sd8388607;
        else
            corr = -meas_reg;
        speed_new = mvalid_reg ? corr : rd_data.speed;
        mode_eff  = mvalid_reg ? mode_in_reg : MODE_STOP;
        is_drive  = (mode_eff == MODE_DRIVE);
        act_ld    = (mode_eff == MODE_BRAKE) ? MODE_BRAKE : MODE_STOP;
        restart   = (rd_data.mode != MODE_DRIVE) ||
                    (rd_data.target > 0 && target_reg < 0) ||
                    (rd_data.target < 0 && target_reg > 0);
        e_new     = 25'(target_reg) - 25'(speed_new);
    end

    // shared multiplier operands; keep the last product steady while finishing
    always_comb
    begin
        mul_a = 33'(e_reg);
        mul_b = 25'(kp_reg);
        unique case (state_reg)
            S_MD:    mul_b = 25'(kd_reg);
            S_MI:    mul_b = 25'(ki_reg);
            S_MN:
            begin
                mul_a = 33'(x_reg);
                mul_b = 25'(nf_reg);
            end
            S_MT, S_FIN:
            begin
                mul_a = 33'(fo_reg);
                mul_b = 25'(tp_reg);
            end
            default: ;
        endcase
    end

    // finishing arithmetic
    logic signed [33:0] loq34, hiq34, u_clamp;
    logic signed [45:0] isum, loq46, hiq46, iclamp;
    logic               hold_int;
    logic signed [31:0] integ_new, filt_new;

    always_comb
    begin
        loq34 = {{2{lo_reg[15]}}, lo_reg, 16'd0};
        hiq34 = {{2{hi_reg[15]}}, hi_reg, 16'd0};
        loq46 = 46'(loq34);
        hiq46 = 46'(hiq34);
        hold_int = (u_reg >= hiq34 && s_reg > 0) || (u_reg <= loq34 && s_reg < 0);
        isum = 46'(integ_reg) + 46'(s_reg);
        if (isum < loq46)
            iclamp = loq46;
        else if (isum > hiq46)
            iclamp = hiq46;
        else
            iclamp = isum;
        integ_new = hold_int ? integ_reg : iclamp[31:0];
        if (u_reg < loq34)
            u_clamp = loq34;
        else if (u_reg > hiq34)
            u_clamp = hiq34;
        else
            u_clamp = u_reg;
        filt_new = sat32(64'(filt_reg) + 64'(prod >>> 24));
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_data = '0;
        if (state_reg == S_LOAD && !is_drive && out_free)
        begin
            wr_en         = 1'b1;
            wr_data.mode  = act_ld;
            wr_data.speed = speed_new;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            wr_en          = 1'b1;
            wr_data.integ  = integ_new;
            wr_data.filt   = filt_new;
            wr_data.target = target_reg;
            wr_data.mode   = MODE_DRIVE;
            wr_data.speed  = speed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            motor_out_reg <= '0;
            action_reg    <= MODE_STOP;
            cmd_reg       <= '0;
            cspeed_reg    <= '0;
            motor_reg     <= '0;
            mode_in_reg   <= MODE_STOP;
            target_reg    <= '0;
            meas_reg      <= '0;
            mvalid_reg    <= 1'b0;
            e_reg         <= '0;
            integ_reg     <= '0;
            filt_reg      <= '0;
            speed_reg     <= '0;
            p_reg         <= '0;
            x_reg         <= '0;
            s_reg         <= '0;
            fo_reg        <= '0;
            u_reg         <= '0;
        end
        else
        begin
            // a new result is loaded exactly when the state is written back
            if (out_valid_reg && !out_stall && !wr_en)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        motor_reg   <= motor_in;
                        mode_in_reg <= requested_mode;
                        target_reg  <= target_speed;
                        meas_reg    <= measured_speed;
                        mvalid_reg  <= measured_valid;
                        state_reg   <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    speed_reg <= speed_new;
                    e_reg     <= e_new;
                    integ_reg <= restart ? 32'sd0 : rd_data.integ;
                    filt_reg  <= restart ? 32'sd0 : rd_data.filt;
                    if (is_drive)
                        state_reg <= S_MP;
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        motor_out_reg <= motor_reg;
                        action_reg    <= act_ld;
                        cmd_reg       <= '0;
                        cspeed_reg    <= speed_new;
                        state_reg     <= S_IDLE;
                    end
                end
                S_MP: state_reg <= S_MD;
                S_MD:
                begin
                    p_reg     <= sat32(64'(prod >>> 4));
                    state_reg <= S_MI;
                end
                S_MI:
                begin
                    x_reg     <= sat32(64'(prod >>> 4) - 64'(filt_reg));
                    state_reg <= S_MN;
                end
                S_MN:
                begin
                    s_reg     <= $signed(prod[48:4]);
                    state_reg <= S_FO;
                end
                S_FO:
                begin
                    fo_reg    <= sat32(64'(prod >>> 16));
                    state_reg <= S_MT;
                end
                S_MT:
                begin
                    u_reg     <= 34'(p_reg) + 34'(integ_reg) + 34'(fo_reg);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        motor_out_reg <= motor_reg;
                        action_reg    <= MODE_DRIVE;
                        cmd_reg       <= u_clamp[31:16];
                        cspeed_reg    <= speed_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/mspc_state_mem.sv =====
module mspc_state_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [mspc_pkg::IDX_W-1:0]    rd_idx,
    output mspc_pkg::state_t              rd_data,
    input  logic                          wr_en,
    input  logic [mspc_pkg::IDX_W-1:0]    wr_idx,
    input  mspc_pkg::state_t              wr_data
);
    import mspc_pkg::*;

    state_t             mem [MOTORS];
    logic [MOTORS-1:0]  valid_reg;
    state_t             rd_word_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            rd_word_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // an entry never written reads as the cleared state
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/mspc_mul.sv =====
module mspc_mul (
    input  logic                clk,
    input  logic signed [32:0]  a,
    input  logic signed [24:0]  b,
    output logic signed [57:0]  prod
);
    logic signed [57:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== dv/motor_speed_pid_controller_test.sv =====
module motor_speed_pid_controller_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mspc_pkg::*;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 1200000;

    typedef struct {
        logic [0:0]         motor;
        logic [1:0]         mode;
        logic signed [23:0] target;
        logic signed [23:0] meas;
        logic               meas_ok;
    } tick_t;

    typedef struct {
        logic [0:0]         motor;
        logic [1:0]         action;
        logic signed [15:0] command;
        logic signed [23:0] speed;
    } act_t;

    typedef struct {
        tick_t tick;
        bit    known;
        act_t  act;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [0:0] motor_in = '0;
    logic [1:0] requested_mode = MODE_STOP;
    logic signed [23:0] target_speed = '0;
    logic signed [23:0] measured_speed = '0;
    logic measured_valid = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [0:0] motor_out;
    logic [1:0] action;
    logic signed [15:0] drive_command;
    logic signed [23:0] corrected_speed;

    motor_speed_pid_controller u_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // controller settings and per-motor loop state
    logic [23:0] kp, kit, kd, nf, tper;
    logic signed [15:0] cmd_lo, cmd_hi;
    logic [1:0] inv_mask;
    logic signed [31:0] integ_q [MOTORS];
    logic signed [31:0] filt_q [MOTORS];
    logic signed [23:0] tgt_q [MOTORS];
    logic [1:0] mode_q [MOTORS];
    logic signed [23:0] speed_q [MOTORS];

    act_t pending_acts [$];
    act_t no_act = '{default: 0};
    int errors = 0;
    int cycles = 0;
    int send_idle = 0, recv_stall = 0;

    function automatic longint floor_shr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clip32(longint x);
        if (x < Q_MIN) return Q_MIN;
        if (x > Q_MAX) return Q_MAX;
        return x;
    endfunction

    function automatic longint bound(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic act_t pid_tick(tick_t t);
        act_t r;
        int m;
        logic [1:0] md;
        longint e, p, d, fo, u, s, ig, fl, loq, hiq, tg, old, ms;
        m = t.motor % MOTORS;
        md = t.mode;
        tg = t.target;
        r.motor = t.motor;
        r.command = '0;
        if (!t.meas_ok)
            md = MODE_STOP;
        else
        begin
            ms = t.meas;
            if (inv_mask[m])
            begin
                ms = -ms;
                if (ms > 8388607) ms = 8388607;
            end
            speed_q[m] = 24'(ms);
        end
        if (md != MODE_DRIVE)
        begin
            if (md != MODE_BRAKE) md = MODE_STOP;
            tgt_q[m] = '0;
            mode_q[m] = md;
            integ_q[m] = '0;
            filt_q[m] = '0;
            r.action = md;
        end
        else
        begin
            old = tgt_q[m];
            loq = longint'(cmd_lo) * 65536;
            hiq = longint'(cmd_hi) * 65536;
            if (mode_q[m] != MODE_DRIVE || (old > 0 && tg < 0) || (old < 0 && tg > 0))
            begin
                integ_q[m] = '0;
                filt_q[m] = '0;
            end
            mode_q[m] = MODE_DRIVE;
            tgt_q[m] = t.target;
            e = tg - longint'(speed_q[m]);
            ig = integ_q[m];
            fl = filt_q[m];
            p = clip32(floor_shr(longint'(kp) * e, 4));
            d = floor_shr(longint'(kd) * e, 4);
            fo = clip32(floor_shr(longint'(nf) * clip32(d - fl), 16));
            u = p + ig + fo;
            s = floor_shr(longint'(kit) * e, 4);
            if (!((u >= hiq && s > 0) || (u <= loq && s < 0)))
                ig = bound(ig + s, loq, hiq);
            integ_q[m] = 32'(ig);
            filt_q[m] = 32'(clip32(fl + floor_shr(fo * longint'(tper), 24)));
            r.command = 16'(floor_shr(bound(u, loq, hiq), 16));
            r.action = MODE_DRIVE;
        end
        r.speed = speed_q[m];
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PROP_GAIN:   kp = val[23:0];
            REG_INT_GAIN_DT: kit = val[23:0];
            REG_DERIV_GAIN:  kd = val[23:0];
            REG_FILTER_COEF: nf = val[23:0];
            REG_SAMPLE_PER:  tper = val[23:0];
            REG_CMD_LOW:     cmd_lo = val[15:0];
            REG_CMD_HIGH:    cmd_hi = val[15:0];
            REG_ENC_INVERT:  inv_mask = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [23:0] p, logic [23:0] i, logic [23:0] d, logic [23:0] n,
                           logic [23:0] t, logic signed [15:0] lo, logic signed [15:0] hi,
                           logic [1:0] inv);
        write_reg(REG_PROP_GAIN, {8'h0, p});
        write_reg(REG_INT_GAIN_DT, {8'h0, i});
        write_reg(REG_DERIV_GAIN, {8'h0, d});
        write_reg(REG_FILTER_COEF, {8'h0, n});
        write_reg(REG_SAMPLE_PER, {8'h0, t});
        write_reg(REG_CMD_LOW, {16'h0, lo});
        write_reg(REG_CMD_HIGH, {16'h0, hi});
        write_reg(REG_ENC_INVERT, {30'h0, inv});
    endtask

    // hold valid through stall; drop it once the item is taken
    task automatic send_tick(tick_t t, bit known, act_t want);
        act_t got;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            @(posedge clk);
            in_valid <= 1'b0;
        end
        @(posedge clk);
        in_valid <= 1'b1;
        motor_in <= t.motor;
        requested_mode <= t.mode;
        target_speed <= t.target;
        measured_speed <= t.meas;
        measured_valid <= t.meas_ok;
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
        got = pid_tick(t);
        pending_acts.push_back(known ? want : got);
    endtask

    task automatic drain();
        while (pending_acts.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic tick_t rand_tick();
        tick_t t;
        int k;
        t.motor = 1'($urandom_range(1));
        k = $urandom_range(99);
        t.mode = k < 70 ? MODE_DRIVE : k < 82 ? MODE_STOP : k < 94 ? MODE_BRAKE : 2'd3;
        k = $urandom_range(9);
        if (k == 0) t.target = 24'($urandom);
        else if (k == 1) t.target = ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
        else t.target = 24'($signed($urandom_range(8000)) - 4000);
        k = $urandom_range(9);
        if (k == 0) t.meas = 24'($urandom);
        else if (k == 1) t.meas = 24'sh800000;
        else t.meas = 24'(t.target + $signed($urandom_range(800)) - 400);
        t.meas_ok = $urandom_range(19) != 0;
        return t;
    endfunction

    // output side: stall at random, check each item
    always @(posedge clk)
    begin
        act_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_acts.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                want = pending_acts.pop_front();
                if (motor_out !== want.motor)
                begin
                    $error("motor_out exp %0d got %0d", want.motor, motor_out);
                    errors++;
                end
                if (action !== want.action)
                begin
                    $error("action exp %0d got %0d", want.action, action);
                    errors++;
                end
                if (drive_command !== want.command)
                begin
                    $error("drive_command exp %0d got %0d", want.command, drive_command);
                    errors++;
                end
                if (corrected_speed !== want.speed)
                begin
                    $error("corrected_speed exp %0d got %0d", want.speed, corrected_speed);
                    errors++;
                end
            end
        end
        out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    end

    row_t dir_rows [] = '{
        '{'{1'b0, MODE_STOP, 24'sd100, 24'sd50, 1'b1}, 1, '{1'b0, MODE_STOP, 16'sd0, 24'sd50}},
        '{'{1'b1, MODE_BRAKE, 24'sd0, -24'sd7, 1'b1}, 1, '{1'b1, MODE_BRAKE, 16'sd0, -24'sd7}},
        '{'{1'b1, 2'd3, 24'sd0, 24'sd9, 1'b1}, 1, '{1'b1, MODE_STOP, 16'sd0, 24'sd9}},
        '{'{1'b0, MODE_DRIVE, 24'sd500, 24'sd1, 1'b0}, 1, '{1'b0, MODE_STOP, 16'sd0, 24'sd50}},
        '{'{1'b0, MODE_DRIVE, 24'sd1600, 24'sd0, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b0, MODE_DRIVE, 24'sd1600, 24'sd800, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b0, MODE_DRIVE, -24'sd1600, 24'sd0, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b0, MODE_DRIVE, 24'sd0, 24'sd0, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b0, MODE_DRIVE, 24'sd3, 24'sd0, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_DRIVE, 24'sh7fffff, 24'sh800000, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_DRIVE, 24'sh7fffff, 24'sh800000, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_DRIVE, 24'sh800000, 24'sh7fffff, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_DRIVE, 24'sh800000, 24'sh7fffff, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_DRIVE, 24'sd10, -24'sd10, 1'b0}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b0, MODE_BRAKE, 24'sd0, 24'sh800000, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}},
        '{'{1'b1, MODE_STOP, 24'sh555555, 24'shaaaaaa, 1'b1}, 0, '{1'b0, 2'd0, 16'sd0, 24'sd0}}
    };

    initial
    begin
        kp = '0; kit = '0; kd = '0; nf = '0; tper = '0;
        cmd_lo = -16'sd32768; cmd_hi = 16'sd32767; inv_mask = '0;
        for (int m = 0; m < MOTORS; m++)
        begin
            integ_q[m] = '0; filt_q[m] = '0; tgt_q[m] = '0;
            mode_q[m] = MODE_STOP; speed_q[m] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset-default rows first, then set gains with motor 1 inverted, then all-ones gains, swapped limits
        for (int i = 0; i < 4; i++)
            send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].act);
        drain();
        set_all(24'h010000, 24'h000800, 24'h002000, 24'h100000, 24'h010000,
                -16'sd1000, 16'sd1000, 2'b10);
        for (int i = 4; i < dir_rows.size(); i++)
            send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].act);
        drain();
        set_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                16'sd100, -16'sd100, 2'b11);
        for (int i = 4; i < 13; i++)
            send_tick(dir_rows[i].tick, 0, dir_rows[i].act);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 50; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 50; end
                default: begin send_idle = 9; recv_stall = 9; end
            endcase
            if (ph == 7)
                set_all('0, '0, '0, '0, '0, -16'sd32768, 16'sd32767, 2'b00);
            else
                set_all(24'($urandom_range(24'h040000)), 24'($urandom_range(24'h004000)),
                        24'($urandom_range(24'h008000)), 24'($urandom_range(24'h200000)),
                        24'($urandom_range(24'h100000)), 16'(-$urandom_range(32768)),
                        16'($urandom_range(32767)), 2'($urandom_range(3)));
            for (int i = 0; i < 105; i++)
                send_tick(rand_tick(), 0, no_act);
            send_idle = 0; recv_stall = 0;
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/mspc_pkg.sv
rtl/mspc_state_mem.sv
rtl/mspc_mul.sv
rtl/motor_speed_pid_controller.sv
dv/motor_speed_pid_controller_test.sv
